@@ design/line_sensor_pid_steering_defines.svh @@
// Assertion macros shared by the line sensor PID steering RTL.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef LINE_SENSOR_PID_STEERING_DEFINES_SVH
`define LINE_SENSOR_PID_STEERING_DEFINES_SVH

// Property must hold at every edge outside reset.
`define LSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define LSPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/lsps_pkg.sv @@
// Shared types, constants and the sensor decode table for line_sensor_pid_steering.
// No dependencies.
package lsps_pkg;

  localparam logic [7:0] KP_RESET        = 8'd10;
  localparam logic [7:0] KI_RESET        = 8'd0;
  localparam logic [7:0] KD_RESET        = 8'd5;
  localparam logic [8:0] MAX_DUTY_RESET  = 9'd256;
  localparam logic [7:0] MIN_DUTY_RESET  = 8'd0;
  localparam logic [4:0] DUTY_STEP_RESET = 5'd31;
  localparam logic [7:0] LEFT_TRIM_RESET = 8'd5;
  localparam logic [3:0] SETPOINT_RESET  = 4'd0;

  localparam logic [7:0] LINE_LOST = 8'hFF;

  // Fixed duties when the line is lost
  localparam logic [9:0] LOST_NEG_LEFT  = 10'd150;
  localparam logic [8:0] LOST_NEG_RIGHT = 9'd185;
  localparam logic [9:0] LOST_POS_LEFT  = 10'd180;
  localparam logic [8:0] LOST_POS_RIGHT = 9'd155;

  localparam logic [15:0] SLOW_OFFSET = 16'd20;
  localparam logic [15:0] FAST_OFFSET = 16'd15;

  localparam int AddrWidth = 5;
  localparam int DataWidth = 32;

  typedef enum logic [2:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_MAX_DUTY  = 3'd3,
    REG_MIN_DUTY  = 3'd4,
    REG_DUTY_STEP = 3'd5,
    REG_LEFT_TRIM = 3'd6,
    REG_SETPOINT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] kp_gain;
    logic [7:0] ki_gain;
    logic [7:0] kd_gain;
    logic [8:0] max_duty;
    logic [7:0] min_duty;
    logic [4:0] duty_step;
    logic [7:0] left_trim;
    logic [3:0] setpoint;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_PROP,
    ST_DERIV,
    ST_INTEG,
    ST_SUM,
    ST_SLOW,
    ST_FAST,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_PROP,
    MUL_DERIV,
    MUL_INTEG,
    MUL_SLOW,
    MUL_FAST
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     calc_err;
    mul_sel_t mul_sel;
    logic     ld_p;
    logic     ld_d;
    logic     ld_int;
    logic     ld_mv;
    logic     ld_slow;
    logic     ld_fast;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic lost_fixed;
  } status_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] pos;
  } decode_t;

  // Active-low pattern to line position
  function automatic decode_t decode_pattern(input logic [7:0] s);
    decode_t r;
    r.hit = 1'b1;
    r.pos = 4'd0;
    case (s)
      8'hFE:        r.pos = -4'sd7;
      8'hF8, 8'hFC: r.pos = -4'sd6;
      8'hFD:        r.pos = -4'sd5;
      8'hF1, 8'hF9: r.pos = -4'sd4;
      8'hFB:        r.pos = -4'sd3;
      8'hE3, 8'hF3: r.pos = -4'sd2;
      8'hF7:        r.pos = -4'sd1;
      8'hE7:        r.pos = 4'sd0;
      8'hEF:        r.pos = 4'sd1;
      8'hC7, 8'hCF: r.pos = 4'sd2;
      8'hDF:        r.pos = 4'sd3;
      8'h8F, 8'h9F: r.pos = 4'sd4;
      8'hBF:        r.pos = 4'sd5;
      8'h1F, 8'h3F: r.pos = 4'sd6;
      8'h7F:        r.pos = 4'sd7;
      default:      r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ design/lsps_cfg.sv @@
// Configuration register file with an APB-style write/read port.
// Depends on lsps_pkg.
module lsps_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsps_pkg::AddrWidth-1:0]   paddr,
  input  logic [lsps_pkg::DataWidth-1:0]   pwdata,
  output logic [lsps_pkg::DataWidth-1:0]   prdata,
  output logic                             pready,
  output lsps_pkg::cfg_t                   cfg
);

  lsps_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = lsps_pkg::reg_idx_t'(paddr[lsps_pkg::AddrWidth-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain   <= lsps_pkg::KP_RESET;
      cfg.ki_gain   <= lsps_pkg::KI_RESET;
      cfg.kd_gain   <= lsps_pkg::KD_RESET;
      cfg.max_duty  <= lsps_pkg::MAX_DUTY_RESET;
      cfg.min_duty  <= lsps_pkg::MIN_DUTY_RESET;
      cfg.duty_step <= lsps_pkg::DUTY_STEP_RESET;
      cfg.left_trim <= lsps_pkg::LEFT_TRIM_RESET;
      cfg.setpoint  <= lsps_pkg::SETPOINT_RESET;
    end else if (wr_en) begin
      case (idx)
        lsps_pkg::REG_KP:        cfg.kp_gain   <= pwdata[7:0];
        lsps_pkg::REG_KI:        cfg.ki_gain   <= pwdata[7:0];
        lsps_pkg::REG_KD:        cfg.kd_gain   <= pwdata[7:0];
        lsps_pkg::REG_MAX_DUTY:  cfg.max_duty  <= pwdata[8:0];
        lsps_pkg::REG_MIN_DUTY:  cfg.min_duty  <= pwdata[7:0];
        lsps_pkg::REG_DUTY_STEP: cfg.duty_step <= pwdata[4:0];
        lsps_pkg::REG_LEFT_TRIM: cfg.left_trim <= pwdata[7:0];
        lsps_pkg::REG_SETPOINT:  cfg.setpoint  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      lsps_pkg::REG_KP:        prdata[7:0] = cfg.kp_gain;
      lsps_pkg::REG_KI:        prdata[7:0] = cfg.ki_gain;
      lsps_pkg::REG_KD:        prdata[7:0] = cfg.kd_gain;
      lsps_pkg::REG_MAX_DUTY:  prdata[8:0] = cfg.max_duty;
      lsps_pkg::REG_MIN_DUTY:  prdata[7:0] = cfg.min_duty;
      lsps_pkg::REG_DUTY_STEP: prdata[4:0] = cfg.duty_step;
      lsps_pkg::REG_LEFT_TRIM: prdata[7:0] = cfg.left_trim;
      lsps_pkg::REG_SETPOINT:  prdata[3:0] = cfg.setpoint;
      default:                 prdata = '0;
    endcase
  end

endmodule

@@ design/lsps_ctrl.sv @@
// Sequencer for one item: decode, error, three PID multiplies, sum, duty multiplies, output.
// Depends on lsps_pkg and line_sensor_pid_steering_defines.svh.
`include "line_sensor_pid_steering_defines.svh"

module lsps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lsps_pkg::status_t  sts,
  output lsps_pkg::cmd_t     cmd
);

  lsps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_sel  = lsps_pkg::MUL_PROP;
    in_stall     = 1'b1;
    case (state)
      lsps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = lsps_pkg::ST_ERR;
        end
      end
      lsps_pkg::ST_ERR: begin
        if (sts.lost_fixed) begin
          state_next = lsps_pkg::ST_OUT;
        end else begin
          cmd.calc_err = 1'b1;
          state_next   = lsps_pkg::ST_PROP;
        end
      end
      lsps_pkg::ST_PROP: begin
        cmd.mul_sel = lsps_pkg::MUL_PROP;
        cmd.ld_p    = 1'b1;
        state_next  = lsps_pkg::ST_DERIV;
      end
      lsps_pkg::ST_DERIV: begin
        cmd.mul_sel = lsps_pkg::MUL_DERIV;
        cmd.ld_d    = 1'b1;
        state_next  = lsps_pkg::ST_INTEG;
      end
      lsps_pkg::ST_INTEG: begin
        cmd.mul_sel = lsps_pkg::MUL_INTEG;
        cmd.ld_int  = 1'b1;
        state_next  = lsps_pkg::ST_SUM;
      end
      lsps_pkg::ST_SUM: begin
        cmd.ld_mv  = 1'b1;
        state_next = lsps_pkg::ST_SLOW;
      end
      lsps_pkg::ST_SLOW: begin
        cmd.mul_sel = lsps_pkg::MUL_SLOW;
        cmd.ld_slow = 1'b1;
        state_next  = lsps_pkg::ST_FAST;
      end
      lsps_pkg::ST_FAST: begin
        cmd.mul_sel = lsps_pkg::MUL_FAST;
        cmd.ld_fast = 1'b1;
        state_next  = lsps_pkg::ST_OUT;
      end
      lsps_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.ld_out = 1'b1;
          state_next = lsps_pkg::ST_IDLE;
        end
      end
      default: state_next = lsps_pkg::ST_IDLE;
    endcase
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `LSPS_ASSERT_NEVER(a_no_overwrite, cmd.ld_out && out_valid && out_stall, "result overwritten while stalled")
  `LSPS_ASSERT(a_accept_to_err, (state == lsps_pkg::ST_IDLE && in_valid) |=> (state == lsps_pkg::ST_ERR), "accepted item did not start")
  `LSPS_ASSERT(a_lost_shortcut, (state == lsps_pkg::ST_ERR && sts.lost_fixed) |=> (state == lsps_pkg::ST_OUT), "line-lost item ran the PID")
  `LSPS_ASSERT(a_valid_from_out, $rose(out_valid) |-> ($past(state) == lsps_pkg::ST_OUT), "result appeared outside output step")

endmodule

@@ design/lsps_dp.sv @@
// Datapath: decode, PID state, one shared 16x16 multiplier, duty mixing, output register.
// Depends on lsps_pkg.
module lsps_dp (
  input  logic               clk,
  input  logic               rst,
  input  lsps_pkg::cfg_t     cfg,
  input  lsps_pkg::cmd_t     cmd,
  output lsps_pkg::status_t  sts,
  input  logic [7:0]         sensor_bits,
  output logic signed [9:0]  left_duty,
  output logic [8:0]         right_duty,
  output logic               left_reverse,
  output logic               right_reverse,
  output logic signed [3:0]  line_position
);

  // Signed divide by eight, truncating toward zero
  function automatic logic [15:0] div8(input logic [15:0] x);
    logic [15:0] b;
    b = x + (x[15] ? 16'd7 : 16'd0);
    return {{3{b[15]}}, b[15:3]};
  endfunction

  function automatic logic [15:0] clamp_duty(input logic [15:0] v, input logic [8:0] hi,
                                             input logic [7:0] lo);
    logic [15:0] r;
    r = v;
    if ($signed(r) < $signed({8'd0, lo})) r = {8'd0, lo};
    if ($signed(r) > $signed({7'd0, hi})) r = {7'd0, hi};
    return r;
  endfunction

  logic [3:0]  position;
  logic        left_dir, right_dir;
  logic        lost_fixed, lost_neg;
  logic [4:0]  err, prev_err, err_next;
  logic [5:0]  rate;
  logic [15:0] acc, p_term, d_term, integral, mv, slow, fast;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_full;
  logic [15:0] prod;
  logic [15:0] max16, trim16, left_raw, right_raw, left_cl, right_cl;
  logic        mv_zero, mv_pos;
  lsps_pkg::decode_t dec;

  assign dec        = lsps_pkg::decode_pattern(sensor_bits);
  assign sts.lost_fixed = lost_fixed;

  // Decode at accept; position and directions are architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      left_dir   <= 1'b0;
      right_dir  <= 1'b0;
      lost_fixed <= 1'b0;
      lost_neg   <= 1'b0;
    end else if (cmd.load_in) begin
      lost_fixed <= 1'b0;
      if (dec.hit) begin
        position  <= dec.pos;
        left_dir  <= 1'b0;
        right_dir <= 1'b0;
      end else if (sensor_bits == lsps_pkg::LINE_LOST && position != 4'd0) begin
        lost_fixed <= 1'b1;
        lost_neg   <= position[3];
        if (position[3]) begin
          left_dir <= 1'b1;
        end else begin
          right_dir <= 1'b1;
        end
      end
    end
  end

  assign err_next = {cfg.setpoint[3], cfg.setpoint} - {position[3], position};

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
    end else if (cmd.ld_int) begin
      integral <= div8(prod);
      prev_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      err  <= err_next;
      rate <= {err_next[4], err_next} - {prev_err[4], prev_err};
      acc  <= integral + {{11{err_next[4]}}, err_next};
    end
  end

  // Shared multiplier; only the low 16 bits are ever needed
  always_comb begin
    case (cmd.mul_sel)
      lsps_pkg::MUL_PROP: begin
        mul_a = {8'd0, cfg.kp_gain};
        mul_b = {{11{err[4]}}, err};
      end
      lsps_pkg::MUL_DERIV: begin
        mul_a = {8'd0, cfg.kd_gain};
        mul_b = {{10{rate[5]}}, rate};
      end
      lsps_pkg::MUL_INTEG: begin
        mul_a = acc;
        mul_b = {8'd0, cfg.ki_gain};
      end
      lsps_pkg::MUL_SLOW: begin
        mul_a = {11'd0, cfg.duty_step} - lsps_pkg::SLOW_OFFSET;
        mul_b = mv;
      end
      lsps_pkg::MUL_FAST: begin
        mul_a = {11'd0, cfg.duty_step};
        mul_b = mv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign prod     = mul_full[15:0];

  always_ff @(posedge clk) begin
    if (cmd.ld_p)    p_term <= div8(prod);
    if (cmd.ld_d)    d_term <= div8(prod);
    if (cmd.ld_mv)   mv     <= p_term + integral + d_term;
    if (cmd.ld_slow) slow   <= prod;
    if (cmd.ld_fast) fast   <= prod;
  end

  // Duty mixing
  assign max16   = {7'd0, cfg.max_duty};
  assign trim16  = {8'd0, cfg.left_trim};
  assign mv_zero = (mv == 16'd0);
  assign mv_pos  = !mv[15] && !mv_zero;

  always_comb begin
    if (mv_pos) begin
      right_raw = max16 - slow;
      left_raw  = max16 - fast - lsps_pkg::FAST_OFFSET - trim16;
    end else begin
      left_raw  = max16 + slow;
      right_raw = max16 + fast - lsps_pkg::FAST_OFFSET;
    end
  end

  assign left_cl  = clamp_duty(left_raw, cfg.max_duty, cfg.min_duty);
  assign right_cl = clamp_duty(right_raw, cfg.max_duty, cfg.min_duty);

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      left_reverse  <= left_dir;
      right_reverse <= right_dir;
      line_position <= position;
      if (lost_fixed) begin
        left_duty  <= lost_neg ? lsps_pkg::LOST_NEG_LEFT : lsps_pkg::LOST_POS_LEFT;
        right_duty <= lost_neg ? lsps_pkg::LOST_NEG_RIGHT : lsps_pkg::LOST_POS_RIGHT;
      end else if (mv_zero) begin
        left_duty  <= {1'b0, cfg.max_duty} - {2'b0, cfg.left_trim};
        right_duty <= cfg.max_duty;
      end else begin
        left_duty  <= left_cl[9:0];
        right_duty <= right_cl[8:0];
      end
    end
  end

endmodule

@@ design/line_sensor_pid_steering.sv @@
// Line-sensor PID steering controller, top level.
// Depends on lsps_pkg, lsps_cfg, lsps_ctrl and lsps_dp.
//
// Usage:
//  - Input channel (in_valid / in_stall / sensor_bits): one item is one 8-bit
//    active-low sensor pattern, taken at an edge with in_valid high and in_stall low.
//  - Output channel (out_valid / out_stall / duties, directions, position):
//    one result item per input item, held stable while out_stall is high.
//  - APB-style port writes the eight gain/duty registers at 4-byte strides;
//    write only while the block is idle. pready is tied high.
//  - Timing: decode on the accept edge, then error, P, D, I, sum and two duty
//    multiplies through one shared 16x16 multiplier, one step per cycle, though
//    the output step may wait. The result is registered in the output step, and
//    no new item is taken until the block is idle again; a line-lost item with
//    fixed duties skips the PID, going from the error step to output.
//  - The output register decouples the sides: a new item is accepted while a
//    finished result still waits; the next result waits in the final step
//    until the receiver takes the previous one.
//  - Reset (rst, synchronous): registers return to their defaults, position,
//    integral, previous error and directions clear, both channels go empty.
module line_sensor_pid_steering (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       sensor_bits,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [9:0]                left_duty,
  output logic [8:0]                       right_duty,
  output logic                             left_reverse,
  output logic                             right_reverse,
  output logic signed [3:0]                line_position,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsps_pkg::AddrWidth-1:0]   paddr,
  input  logic [lsps_pkg::DataWidth-1:0]   pwdata,
  output logic [lsps_pkg::DataWidth-1:0]   prdata,
  output logic                             pready
);

  lsps_pkg::cfg_t    cfg;
  lsps_pkg::cmd_t    cmd;
  lsps_pkg::status_t sts;

  // Register file
  lsps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Step sequencer and handshake control
  lsps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state
  lsps_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .sensor_bits   (sensor_bits),
    .left_duty     (left_duty),
    .right_duty    (right_duty),
    .left_reverse  (left_reverse),
    .right_reverse (right_reverse),
    .line_position (line_position)
  );

endmodule

@@ tb/tb_line_sensor_pid_steering.sv @@
// Testbench for line_sensor_pid_steering: random and directed sensor patterns, checked
// against an in-bench model of the PID steering math under several register settings.
// Depends on lsps_pkg and the line_sensor_pid_steering RTL only.
module tb_line_sensor_pid_steering;

  // One motor command as seen on the output channel, raw port bits
  typedef struct packed {
    logic [9:0] left;
    logic [8:0] right;
    logic       left_rev;
    logic       right_rev;
    logic [3:0] pos;
  } steer_cmd_t;

  logic clk;
  logic rst = 1'b1;

  // Every block input starts at a known value
  logic                           in_valid    = 1'b0;
  logic [7:0]                     sensor_bits = 8'h00;
  logic                           out_stall   = 1'b0;
  logic                           psel        = 1'b0;
  logic                           penable     = 1'b0;
  logic                           pwrite      = 1'b0;
  logic [lsps_pkg::AddrWidth-1:0] paddr       = '0;
  logic [lsps_pkg::DataWidth-1:0] pwdata      = '0;

  logic                           in_stall;
  logic                           out_valid;
  logic signed [9:0]              left_duty;
  logic [8:0]                     right_duty;
  logic                           left_reverse;
  logic                           right_reverse;
  logic signed [3:0]              line_position;
  logic [lsps_pkg::DataWidth-1:0] prdata;
  logic                           pready;

  line_sensor_pid_steering dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sensor_bits   (sensor_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_duty     (left_duty),
    .right_duty    (right_duty),
    .left_reverse  (left_reverse),
    .right_reverse (right_reverse),
    .line_position (line_position),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Sensor items waiting for the driver, and commands waiting for the monitor
  logic [7:0] pending_sensor[$];
  steer_cmd_t expected_cmds[$];
  steer_cmd_t want_cmd;
  int         err_count = 0;
  // High during the stretch where neither side idles
  logic       quiet = 1'b0;

  // Listed sensor patterns and the line position each one decodes to
  logic [7:0] track_pat[21] = '{8'hFE, 8'hF8, 8'hFC, 8'hFD, 8'hF1, 8'hF9, 8'hFB,
                                8'hE3, 8'hF3, 8'hF7, 8'hE7, 8'hEF, 8'hC7, 8'hCF,
                                8'hDF, 8'h8F, 8'h9F, 8'hBF, 8'h1F, 8'h3F, 8'h7F};
  int         track_pos[21] = '{-7, -6, -6, -5, -4, -4, -3,
                                -2, -2, -1,  0,  1,  2,  2,
                                 3,  4,  4,  5,  6,  6,  7};

  // Register mirror, starts at the reset values
  int kp_g = 10, ki_g = 0, kd_g = 5;
  int max_d = 256, min_d = 0, step_d = 31, trim_l = 5, target_pos = 0;

  // Controller state mirror
  int   line_pos = 0;
  int   integ    = 0;
  int   prev_err = 0;
  logic left_dir = 1'b0, right_dir = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Keep low 16 bits as a signed value
  function automatic int wrap16(input int v);
    logic signed [15:0] w;
    w = v[15:0];
    return w;
  endfunction

  // Raise to min first, then lower to max: max wins when min > max
  function automatic int clamp_duty(input int v);
    if (v < min_d) v = min_d;
    if (v > max_d) v = max_d;
    return v;
  endfunction

  // Advances the controller mirror by one sensor item, returns the command
  function automatic steer_cmd_t steer_predict(input logic [7:0] s);
    steer_cmd_t c;
    logic       hit, lost_fixed;
    int         err, p_term, d_term, acc, mv, slow, fast, left, right;
    hit = 1'b0;
    lost_fixed = 1'b0;
    left = 0;
    right = 0;
    for (int k = 0; k < 21; k++) begin
      if (track_pat[k] == s) begin
        hit = 1'b1;
        line_pos = track_pos[k];
      end
    end
    if (hit) begin
      left_dir = 1'b0;
      right_dir = 1'b0;
    end else if (s == 8'hFF) begin
      // line lost: fixed turn toward the last seen side, PID left alone
      if (line_pos < 0) begin
        left = 150; right = 185; left_dir = 1'b1; lost_fixed = 1'b1;
      end else if (line_pos > 0) begin
        left = 180; right = 155; right_dir = 1'b1; lost_fixed = 1'b1;
      end
    end
    if (!lost_fixed) begin
      err = target_pos - line_pos;
      p_term = (kp_g * err) / 8;
      d_term = (kd_g * (err - prev_err)) / 8;
      acc = wrap16(integ + err);
      acc = wrap16(acc * ki_g);
      integ = acc / 8;
      prev_err = err;
      mv = wrap16(p_term + integ + d_term);
      if (mv == 0) begin
        // straight ahead: unclamped, left may go negative
        left = max_d - trim_l;
        right = max_d;
      end else begin
        slow = (step_d - 20) * mv;
        fast = step_d * mv;
        if (mv > 0) begin
          right = wrap16(max_d - slow);
          left = wrap16(max_d - fast - 15 - trim_l);
        end else begin
          left = wrap16(max_d + slow);
          right = wrap16(max_d + fast - 15);
        end
        left = clamp_duty(left);
        right = clamp_duty(right);
      end
    end
    c.left = left[9:0];
    c.right = right[8:0];
    c.left_rev = left_dir;
    c.right_rev = right_dir;
    c.pos = line_pos[3:0];
    return c;
  endfunction

  // Driver: holds an item until taken, otherwise loads the next one or idles
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_cmds.push_back(steer_predict(sensor_bits));
      if (!in_valid || !in_stall) begin
        if (pending_sensor.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
          in_valid <= 1'b1;
          sensor_bits <= pending_sensor.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, each taken result checked against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 12);
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: left %0d right %0d lrev %0b rrev %0b pos %0d",
                     left_duty, right_duty, left_reverse, right_reverse, line_position);
          err_count++;
        end else begin
          want_cmd = expected_cmds.pop_front();
          if (left_duty !== want_cmd.left || right_duty !== want_cmd.right ||
              left_reverse !== want_cmd.left_rev || right_reverse !== want_cmd.right_rev ||
              line_position !== want_cmd.pos) begin
            if (err_count < 10) begin
              $write("mismatch: exp left %0d right %0d lrev %0b rrev %0b pos %0d,",
                     $signed(want_cmd.left), want_cmd.right, want_cmd.left_rev,
                     want_cmd.right_rev, $signed(want_cmd.pos));
              $display(" got left %0d right %0d lrev %0b rrev %0b pos %0d",
                       left_duty, right_duty, left_reverse, right_reverse, line_position);
            end
            err_count++;
          end
        end
      end
    end
  end

  // APB write: setup, access, done at the edge with pready high; mirror follows
  task automatic reg_write(input lsps_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lsps_pkg::REG_KP:        kp_g = val[7:0];
      lsps_pkg::REG_KI:        ki_g = val[7:0];
      lsps_pkg::REG_KD:        kd_g = val[7:0];
      lsps_pkg::REG_MAX_DUTY:  max_d = val[8:0];
      lsps_pkg::REG_MIN_DUTY:  min_d = val[7:0];
      lsps_pkg::REG_DUTY_STEP: step_d = val[4:0];
      lsps_pkg::REG_LEFT_TRIM: trim_l = val[7:0];
      lsps_pkg::REG_SETPOINT:  target_pos = $signed(val[3:0]);
      default: ;
    endcase
  endtask

  task automatic program_gains(input logic [31:0] kp, ki, kd, maxd, mind, step, trim, sp);
    reg_write(lsps_pkg::REG_KP, kp);
    reg_write(lsps_pkg::REG_KI, ki);
    reg_write(lsps_pkg::REG_KD, kd);
    reg_write(lsps_pkg::REG_MAX_DUTY, maxd);
    reg_write(lsps_pkg::REG_MIN_DUTY, mind);
    reg_write(lsps_pkg::REG_DUTY_STEP, step);
    reg_write(lsps_pkg::REG_LEFT_TRIM, trim);
    reg_write(lsps_pkg::REG_SETPOINT, sp);
  endtask

  // Block is idle once nothing is queued, offered or outstanding; then a short pause
  task automatic wait_drained();
    @(negedge clk);
    while (pending_sensor.size() != 0 || in_valid || expected_cmds.size() != 0)
      @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Mostly listed patterns, with line-lost runs and arbitrary bytes as noise
  task automatic queue_random(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 70)
        pending_sensor.push_back(track_pat[$urandom_range(20)]);
      else if (r < 85)
        pending_sensor.push_back(8'hFF);
      else
        pending_sensor.push_back(8'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: zero output, both lost turns, lost at center,
    // unlisted patterns, extremes of the sensor byte
    pending_sensor = '{8'hE7, 8'hE7, 8'hFE, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                       8'hE7, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hF7, 8'hEF, 8'hF8,
                       8'h1F, 8'hFF, 8'hDF, 8'h00, 8'hFB, 8'h3F, 8'hE7, 8'hE7};
    wait_drained();

    // Top of every register range, setpoint at +7
    program_gains(255, 255, 255, 511, 255, 31, 255, 4'h7);
    pending_sensor = '{8'hFE, 8'h7F, 8'hE7, 8'hFF, 8'hFE, 8'hFF};
    queue_random(100);
    wait_drained();

    // Bottom of every range, setpoint at -8
    program_gains(0, 0, 0, 0, 0, 0, 0, 4'h8);
    pending_sensor = '{8'h7F, 8'hFE, 8'hE7, 8'hFF, 8'h00};
    queue_random(100);
    wait_drained();

    // Typical tuning, run with no idling on either side
    program_gains(40, 9, 20, 256, 30, 29, 5, 0);
    quiet = 1'b1;
    queue_random(200);
    wait_drained();
    quiet = 1'b0;

    // Random settings, all register bits exercised
    repeat (6) begin
      program_gains($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
      queue_random(125);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (err_count == 0 && expected_cmds.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
